### rtl/core/r2fft_pkg.sv
// Package for the radix-2 FFT block: widths, twiddle table and helpers.
// No dependencies.
package r2fft_pkg;
  localparam int OUT_BITS = 23;
  localparam int TW_FRAC  = 15;
  localparam int DEPTH    = 64;
  localparam int AW       = 6;

  typedef logic signed [OUT_BITS-1:0] word_t;

  // round(cos(2*pi*j/64) * 32768), j = 0..16
  function automatic logic signed [17:0] quarter_cos(input logic [4:0] r);
    logic signed [17:0] v;
    case (r)
      5'd0: v = 18'sd32768;   5'd1: v = 18'sd32610;   5'd2: v = 18'sd32138;
      5'd3: v = 18'sd31357;   5'd4: v = 18'sd30274;   5'd5: v = 18'sd28899;
      5'd6: v = 18'sd27246;   5'd7: v = 18'sd25330;   5'd8: v = 18'sd23170;
      5'd9: v = 18'sd20788;   5'd10: v = 18'sd18205;  5'd11: v = 18'sd15447;
      5'd12: v = 18'sd12540;  5'd13: v = 18'sd9512;   5'd14: v = 18'sd6393;
      5'd15: v = 18'sd3212;   default: v = 18'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [17:0] tw_cos(input logic [5:0] j);
    logic [1:0] q;
    logic [4:0] r;
    logic signed [17:0] v;
    q = j[5:4];
    r = {1'b0, j[3:0]};
    case (q)
      2'd0: v = quarter_cos(r);
      2'd1: v = -quarter_cos(5'd16 - r);
      2'd2: v = -quarter_cos(r);
      default: v = quarter_cos(5'd16 - r);
    endcase
    return v;
  endfunction

  function automatic word_t sat_out(input logic signed [OUT_BITS+1:0] v);
    word_t r;
    if (v > $signed({3'b000, {(OUT_BITS-1){1'b1}}})) r = {1'b0, {(OUT_BITS-1){1'b1}}};
    else if (v < $signed({3'b111, {(OUT_BITS-1){1'b0}}})) r = {1'b1, {(OUT_BITS-1){1'b0}}};
    else r = v[OUT_BITS-1:0];
    return r;
  endfunction
endpackage

### rtl/core/radix2_fft_and_inverse.sv
// Radix-2 FFT / inverse FFT top level with one shared butterfly unit.
// Depends on r2fft_pkg.
//
// Input channel: sample_valid/sample_stall carry one complex sample per beat;
// a beat with sample_last closes the set. After the closing beat N = next
// power of two is found, then the set is copied in bit-reversed order with
// the padding written as zeros (per entry a registered read, then a write).
// Then log2(N) stages of N outputs each run on one complex multiplier: each
// output passes three steps (memory read, multiply, add/write), one output
// at a time through the single butterfly unit and its buffer memories.
// Results leave at out_valid/out_stall, one per cycle while not stalled, in
// natural order; a stall holds the output register and the read sequencer.
// The input is stalled from the closing beat until the last result is taken.
// Reset (rst, synchronous) clears the sample counter, the dropped-sample
// flag, out_valid, the mode register and the sequencer state; buffer
// contents are not cleared and need no clearing pass.
// inverse_mode lies at APB address 0.
module radix2_fft_and_inverse #(
  parameter int MAX_POINTS  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [0:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_re,
  input  logic signed [SAMPLE_BITS-1:0] sample_im,
  input  logic                          sample_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [22:0]            out_re,
  output logic signed [22:0]            out_im,
  output logic [5:0]                    bin_index,
  output logic                          bin_last,
  output logic                          overflow_flag
);
  localparam int AW = r2fft_pkg::AW;
  localparam int OB = r2fft_pkg::OUT_BITS;
  localparam logic [6:0] MAXP = 7'(MAX_POINTS);

  typedef enum logic [2:0] {LOAD, PAD, REV, REVW, BRD, BMUL, BWR, OUTP} state_t;

  state_t state;
  logic inverse_mode;
  logic [6:0] sample_count;
  logic dropped_seen;
  logic [6:0] n;
  logic [2:0] lg, stg;
  logic [6:0] idx;
  logic sel;       // 0: data in mem_a, 1: data in mem_b
  logic [2*OB-1:0] mem_a [r2fft_pkg::DEPTH];
  logic [2*OB-1:0] mem_b [r2fft_pkg::DEPTH];
  logic [2*OB-1:0] rd_a, rd_b;   // read data (a operand, b operand)
  logic signed [40:0] pr, pi;
  logic [5:0] jr;

  // APB
  assign pready = 1'b1;
  assign prdata = {31'd0, inverse_mode};
  always_ff @(posedge clk) begin
    if (rst) inverse_mode <= 1'b0;
    else if (psel && penable && pwrite && paddr == 1'b0) inverse_mode <= pwdata[0];
  end

  assign sample_stall = (state != LOAD);
  wire in_acc = sample_valid && !sample_stall;

  // butterfly addressing for output index idx within stage stg
  logic [6:0] p, kk, off, ia, ib;
  always_comb begin
    p   = 7'd1 << stg;
    off = idx & ~((p << 1) - 7'd1);
    kk  = idx & ((p << 1) - 7'd1);
    ia  = off + (kk & (p - 7'd1));
    ib  = ia + p;
    jr  = 6'((kk * (7'd32 >> stg)));
  end

  // bit reversal of idx over lg bits
  logic [AW-1:0] rev;
  always_comb begin
    rev = '0;
    for (int b = 0; b < AW; b++)
      if (b < lg) rev[lg - 3'(b) - 3'd1] = idx[b];
  end

  logic signed [17:0] cw, sw, wi;
  always_comb begin
    cw = r2fft_pkg::tw_cos(jr);
    sw = r2fft_pkg::tw_cos(jr + 6'd48);
    wi = inverse_mode ? sw : -sw;
  end

  wire signed [OB-1:0] bre = rd_b[2*OB-1:OB];
  wire signed [OB-1:0] bim = rd_b[OB-1:0];
  wire signed [OB-1:0] are = rd_a[2*OB-1:OB];
  wire signed [OB-1:0] aim = rd_a[OB-1:0];
  wire signed [OB+1:0] sre = are + 25'((pr + 41'sd16384) >>> 15);
  wire signed [OB+1:0] sim = aim + 25'((pi + 41'sd16384) >>> 15);

  // inverse scaling on the output read
  wire signed [OB-1:0] ore = rd_a[2*OB-1:OB];
  wire signed [OB-1:0] oim = rd_a[OB-1:0];
  wire signed [OB:0] rre = (lg == 0) ? (OB+1)'(ore) :
      (OB+1)'(($signed({ore[OB-1], ore}) + ((OB+1)'(1) << (lg - 3'd1))) >>> lg);
  wire signed [OB:0] rim = (lg == 0) ? (OB+1)'(oim) :
      (OB+1)'(($signed({oim[OB-1], oim}) + ((OB+1)'(1) << (lg - 3'd1))) >>> lg);

  logic rd_ok;   // rd_a holds item idx-1 for output
  logic [6:0] oidx;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD; sample_count <= '0; dropped_seen <= 1'b0;
      out_valid <= 1'b0; rd_ok <= 1'b0;
    end else begin
      unique case (state)
        LOAD: if (in_acc) begin
          if (sample_count < MAXP) begin
            mem_a[sample_count[AW-1:0]] <= {OB'(sample_re), OB'(sample_im)};
            sample_count <= sample_count + 7'd1;
          end else dropped_seen <= 1'b1;
          if (sample_last) begin
            n <= 7'd1; lg <= 3'd0; state <= PAD;
          end
        end
        PAD: begin
          if (n < sample_count && n < 7'd64) begin
            n <= n << 1; lg <= lg + 3'd1;
          end else begin
            idx <= 7'd0; state <= REV;
          end
        end
        REV: begin
          // registered read of the natural-order entry
          rd_a <= mem_a[idx[AW-1:0]];
          state <= REVW;
        end
        REVW: begin
          // write it bit reversed into mem_b; padding entries become zero
          mem_b[rev] <= (idx < sample_count) ? rd_a : '0;
          if (idx + 7'd1 == n) begin
            idx <= 7'd0; stg <= 3'd0; sel <= 1'b1; sample_count <= 7'd0;
            rd_ok <= 1'b0;
            state <= (lg == 3'd0) ? OUTP : BRD;
          end else begin
            idx <= idx + 7'd1; state <= REV;
          end
        end
        BRD: begin
          rd_a <= sel ? mem_b[ia[AW-1:0]] : mem_a[ia[AW-1:0]];
          rd_b <= sel ? mem_b[ib[AW-1:0]] : mem_a[ib[AW-1:0]];
          state <= BMUL;
        end
        BMUL: begin
          pr <= 41'(bre) * 41'(cw) - 41'(bim) * 41'(wi);
          pi <= 41'(bre) * 41'(wi) + 41'(bim) * 41'(cw);
          state <= BWR;
        end
        BWR: begin
          if (sel) mem_a[idx[AW-1:0]] <= {r2fft_pkg::sat_out(sre), r2fft_pkg::sat_out(sim)};
          else     mem_b[idx[AW-1:0]] <= {r2fft_pkg::sat_out(sre), r2fft_pkg::sat_out(sim)};
          if (idx + 7'd1 == n) begin
            idx <= 7'd0; sel <= ~sel;
            if (stg + 3'd1 == lg) begin state <= OUTP; rd_ok <= 1'b0; end
            else begin stg <= stg + 3'd1; state <= BRD; end
          end else begin
            idx <= idx + 7'd1; state <= BRD;
          end
        end
        OUTP: begin
          // one read ahead into rd_a, output register behind it
          if (!out_valid || !out_stall) begin
            if (rd_ok) begin
              out_valid <= 1'b1;
              out_re <= inverse_mode ? OB'(rre) : ore;
              out_im <= inverse_mode ? OB'(rim) : oim;
              bin_index <= oidx[5:0];
              bin_last <= (oidx + 7'd1 == n);
              overflow_flag <= dropped_seen;
            end else out_valid <= 1'b0;
            if (rd_ok && oidx + 7'd1 == n) begin
              rd_ok <= 1'b0; idx <= n;
            end else if (idx < n) begin
              rd_a <= sel ? mem_b[idx[AW-1:0]] : mem_a[idx[AW-1:0]];
              oidx <= idx; idx <= idx + 7'd1; rd_ok <= 1'b1;
            end else rd_ok <= 1'b0;
            // last beat taken: out_valid drops through the branch above
            if (out_valid && bin_last && !rd_ok) begin
              state <= LOAD; dropped_seen <= 1'b0;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

  // checks
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != LOAD) |-> sample_stall) else $error("input taken while busy");
  a_out_only_outp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == OUTP)) else $error("result outside output phase");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    sample_count <= MAXP) else $error("sample count overrun");
endmodule
